// ===== rtl/core/ctq_pkg.sv =====
`timescale 1ns / 1ps

package ctq_pkg;

	typedef enum logic [2:0] {
		ST_DISABLED  = 3'd0,
		ST_ENABLED   = 3'd1,
		ST_COVER_ON  = 3'd2,
		ST_COVER_OFF = 3'd3,
		ST_FAULT     = 3'd4
	} status_t;

	typedef enum logic {
		OP_POLL = 1'b0,
		OP_ARM  = 1'b1
	} opcode_t;

	localparam logic [1:0] REG_COVER_ON_LEVEL     = 2'd0;
	localparam logic [1:0] REG_WINDOW_MARGIN      = 2'd1;
	localparam logic [1:0] REG_SETTLE_SECONDS     = 2'd2;
	localparam logic [1:0] REG_RAPID_CHANGE_LIMIT = 2'd3;

	localparam int CFG_DATA_W = 12;
	localparam int CFG_INDEX_W = 2;
	localparam logic [4:0] COUNT_MAX = 5'd31;

	typedef struct packed {
		opcode_t     opcode;
		logic        change_seen;
		logic [31:0] now_seconds;
		logic [11:0] proximity_sample;
		logic        read_ok;
	} item_t;

	typedef struct packed {
		logic [11:0] cover_on_level;
		logic [7:0]  window_margin;
		logic [7:0]  settle_seconds;
		logic [3:0]  rapid_change_limit;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] deadline;
		logic        armed;
		logic [4:0]  count;
	} state_t;

	typedef struct packed {
		status_t status;
		logic    changed;
	} result_t;

endpackage

// ===== rtl/core/cover_tamper_qualifier_unit.sv =====
`timescale 1ns / 1ps
// A transaction accepted into the input register is judged there, and its result is
// registered in the result register, from which it is offered.
// Throughput: one transaction per cycle unless the output stalls; the input register and
// the result register advance together whenever the result register is empty or being taken.
// Reset clears the status to disabled, the deadline, the armed flag, the change count and the valid flags.

module cover_tamper_qualifier_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic        change_seen,
	input  logic [31:0] now_seconds,
	input  logic [11:0] proximity_sample,
	input  logic        read_ok,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  cover_status,
	output logic        status_changed,
	input  logic        cfg_we,
	input  logic [ctq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ctq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import ctq_pkg::*;

	cfg_t    cfg_q;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    load_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t result_nxt;
	result_t result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cover_on_level     <= 12'd208;
			cfg_q.window_margin      <= 8'd48;
			cfg_q.settle_seconds     <= 8'd5;
			cfg_q.rapid_change_limit <= 4'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COVER_ON_LEVEL:     cfg_q.cover_on_level     <= cfg_wdata[11:0];
				REG_WINDOW_MARGIN:      cfg_q.window_margin      <= cfg_wdata[7:0];
				REG_SETTLE_SECONDS:     cfg_q.settle_seconds     <= cfg_wdata[7:0];
				REG_RAPID_CHANGE_LIMIT: cfg_q.rapid_change_limit <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign item_in.opcode           = opcode_t'(opcode);
	assign item_in.change_seen      = change_seen;
	assign item_in.now_seconds      = now_seconds;
	assign item_in.proximity_sample = proximity_sample;
	assign item_in.read_ok          = read_ok;

	assign advance  = !out_valid || !out_stall;
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	ctq_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load_s1),
		.in_valid (in_valid),
		.item_in  (item_in),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ctq_eval u_eval (
		.item      (item_s1),
		.cfg       (cfg_q),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.result    (result_nxt)
	);

	ctq_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.state_nxt  (state_nxt),
		.result_nxt (result_nxt),
		.state_q    (state_q),
		.valid_s2   (out_valid),
		.result_s2  (result_s2)
	);

	assign cover_status   = result_s2.status;
	assign status_changed = result_s2.changed;

	// A stall on the input only arises from a full input register.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	// The delivered status is the status that the state register now holds.
	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1) |=> (result_s2.status == state_q.status))
		else $error("result status differs from stored status");

	// A disabled result never reports a change, since once left the disabled status is never entered again.
	a_disabled_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_s2.status == ST_DISABLED) |-> !result_s2.changed)
		else $error("disabled status reported as a change");

	// A running deadline exists only while the block is enabled.
	a_armed_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.armed |-> (state_q.status != ST_DISABLED))
		else $error("deadline armed while disabled");

endmodule

// ===== rtl/core/ctq_in_reg.sv =====
`timescale 1ns / 1ps

module ctq_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic          in_valid,
	input  ctq_pkg::item_t item_in,
	output logic          valid_s1,
	output ctq_pkg::item_t item_s1
);
	import ctq_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= item_in;
		end
	end

endmodule

// ===== rtl/core/ctq_eval.sv =====
`timescale 1ns / 1ps

module ctq_eval (
	input  ctq_pkg::item_t   item,
	input  ctq_pkg::cfg_t    cfg,
	input  ctq_pkg::state_t  state_cur,
	output ctq_pkg::state_t  state_nxt,
	output ctq_pkg::result_t result
);
	import ctq_pkg::*;

	logic [31:0] restart_deadline;
	logic [4:0]  count_inc;
	logic [12:0] low_sum;
	logic [12:0] high_sum;
	logic        inside_window;
	logic        expired;

	assign restart_deadline = item.now_seconds + {24'd0, cfg.settle_seconds};
	assign count_inc = (state_cur.count < COUNT_MAX) ? state_cur.count + 5'd1 : state_cur.count;

	// Both bounds are formed one bit wider so neither side of the window wraps.
	assign low_sum  = {1'b0, item.proximity_sample} + {5'd0, cfg.window_margin};
	assign high_sum = {1'b0, cfg.cover_on_level} + {5'd0, cfg.window_margin};
	assign inside_window = (low_sum > {1'b0, cfg.cover_on_level}) &&
		({1'b0, item.proximity_sample} < high_sum);
	assign expired = state_cur.armed && (item.now_seconds > state_cur.deadline);

	always_comb begin
		state_nxt = state_cur;
		if (item.opcode == OP_ARM) begin
			state_nxt.status   = ST_ENABLED;
			state_nxt.deadline = restart_deadline;
			state_nxt.armed    = 1'b1;
			state_nxt.count    = 5'd0;
		end else if (state_cur.status != ST_DISABLED) begin
			if (item.change_seen) begin
				state_nxt.deadline = restart_deadline;
				state_nxt.armed    = 1'b1;
				state_nxt.count    = count_inc;
				if (count_inc > {1'b0, cfg.rapid_change_limit}) begin
					state_nxt.status = ST_COVER_OFF;
					state_nxt.count  = 5'd0;
				end
			end else if (expired) begin
				state_nxt.count    = 5'd0;
				state_nxt.armed    = 1'b0;
				state_nxt.deadline = 32'd0;
				if (!item.read_ok) begin
					state_nxt.status = ST_FAULT;
				end else if (inside_window) begin
					state_nxt.status = ST_COVER_ON;
				end else begin
					state_nxt.status = ST_COVER_OFF;
				end
			end
		end
		result.status  = state_nxt.status;
		result.changed = (state_nxt.status != state_cur.status);
	end

endmodule

// ===== rtl/core/ctq_state.sv =====
`timescale 1ns / 1ps

module ctq_state (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             valid_s1,
	input  ctq_pkg::state_t  state_nxt,
	input  ctq_pkg::result_t result_nxt,
	output ctq_pkg::state_t  state_q,
	output logic             valid_s2,
	output ctq_pkg::result_t result_s2
);
	import ctq_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.status   <= ST_DISABLED;
			state_q.deadline <= 32'd0;
			state_q.armed    <= 1'b0;
			state_q.count    <= 5'd0;
			valid_s2         <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= result_nxt;
		end
	end

endmodule

// ===== dv/tamper_scoreboard_pkg.sv =====
`timescale 1ns / 1ps

package tamper_scoreboard_pkg;
	import ctq_pkg::*;

	class tamper_scoreboard;
		status_t     status_now;
		logic [31:0] deadline;
		logic        armed;
		logic [4:0]  change_count;
		logic [11:0] level;
		logic [7:0]  margin;
		logic [7:0]  settle;
		logic [3:0]  limit;
		result_t     expected_q[$];
		int          errors;

		function new();
			status_now = ST_DISABLED;
			deadline = '0;
			armed = 1'b0;
			change_count = '0;
			level = 12'd208;
			margin = 8'd48;
			settle = 8'd5;
			limit = 4'd3;
			errors = 0;
		endfunction

		function void write_register(logic [CFG_INDEX_W-1:0] index,
				logic [CFG_DATA_W-1:0] value);
			case (index)
			REG_COVER_ON_LEVEL:     level = value;
			REG_WINDOW_MARGIN:      margin = value[7:0];
			REG_SETTLE_SECONDS:     settle = value[7:0];
			REG_RAPID_CHANGE_LIMIT: limit = value[3:0];
			default: ;
			endcase
		endfunction

		// Advances the predicted state by one transaction and queues its result.
		function void note_input(item_t item);
			status_t prior;
			result_t res;
			int      low_sum;
			int      high_sum;
			prior = status_now;
			if (item.opcode == OP_ARM) begin
				status_now = ST_ENABLED;
				deadline = item.now_seconds + settle;
				armed = 1'b1;
				change_count = '0;
			end else if (status_now != ST_DISABLED) begin
				if (item.change_seen) begin
					deadline = item.now_seconds + settle;
					armed = 1'b1;
					if (change_count < COUNT_MAX)
						change_count++;
					if (change_count > limit) begin
						status_now = ST_COVER_OFF;
						change_count = '0;
					end
				end else if (armed && item.now_seconds > deadline) begin
					change_count = '0;
					armed = 1'b0;
					deadline = '0;
					// The window is open on both sides and its bounds never wrap.
					low_sum = int'(item.proximity_sample) + int'(margin);
					high_sum = int'(level) + int'(margin);
					if (!item.read_ok)
						status_now = ST_FAULT;
					else if (low_sum > int'(level) && int'(item.proximity_sample) < high_sum)
						status_now = ST_COVER_ON;
					else
						status_now = ST_COVER_OFF;
				end
			end
			res.status = status_now;
			res.changed = (status_now != prior);
			expected_q.push_back(res);
		endfunction

		function void check_result(logic [2:0] status, logic changed);
			result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, actual status %0d changed %0b",
					$time, status, changed);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (status !== want.status) begin
				$display("%0t: cover_status expected %0d actual %0d",
					$time, want.status, status);
				errors++;
			end
			if (changed !== want.changed) begin
				$display("%0t: status_changed expected %0b actual %0b",
					$time, want.changed, changed);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import ctq_pkg::*;
	import tamper_scoreboard_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 130;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic                   opcode;
	logic                   change_seen;
	logic [31:0]            now_seconds;
	logic [11:0]            proximity_sample;
	logic                   read_ok;
	logic                   out_valid;
	logic                   out_stall;
	logic [2:0]             cover_status;
	logic                   status_changed;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	tamper_scoreboard sb;
	int               send_idle_pct = 0;
	int               stall_pct = 0;
	int               hold_left = 0;
	int               cycle_count = 0;
	int               burst_left = 0;
	logic [11:0]      gen_level;
	logic [7:0]       gen_margin;
	logic [7:0]       gen_settle;
	logic [3:0]       gen_limit;
	logic [31:0]      gen_time;

	cover_tamper_qualifier_unit u_top (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(cover_status, status_changed);
	end

	// A requested hold-off is counted down here, so the sender keeps running meanwhile.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic send(input opcode_t op, input logic chg, input logic [31:0] t,
			input logic [11:0] s, input logic ok);
		item_t item;
		item.opcode = op;
		item.change_seen = chg;
		item.now_seconds = t;
		item.proximity_sample = s;
		item.read_ok = ok;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode = item.opcode;
		change_seen = item.change_seen;
		now_seconds = item.now_seconds;
		proximity_sample = item.proximity_sample;
		read_ok = item.read_ok;
		do @(posedge clk); while (in_stall);
		sb.note_input(item);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_wdata = value;
		@(posedge clk);
		sb.write_register(index, value);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply_config(input logic [11:0] level, input logic [7:0] margin,
			input logic [7:0] settle, input logic [3:0] limit);
		write_cfg(REG_COVER_ON_LEVEL, level);
		write_cfg(REG_WINDOW_MARGIN, {4'd0, margin});
		write_cfg(REG_SETTLE_SECONDS, {4'd0, settle});
		write_cfg(REG_RAPID_CHANGE_LIMIT, {8'd0, limit});
		gen_level = level;
		gen_margin = margin;
		gen_settle = settle;
		gen_limit = limit;
	endtask

	// Mostly a time line that moves forward, with change bursts and samples at the
	// window edges; a few transactions are pure noise.
	task automatic send_random(input bit first);
		opcode_t     op;
		logic        chg;
		logic [31:0] t;
		logic [11:0] s;
		logic        ok;
		int          r;
		if (!first && $urandom_range(99) < 4) begin
			op = opcode_t'(1'($urandom_range(1)));
			chg = 1'($urandom_range(1));
			t = $urandom;
			s = 12'($urandom_range(4095));
			ok = 1'($urandom_range(1));
		end else begin
			op = (first || $urandom_range(99) < 6) ? OP_ARM : OP_POLL;
			r = $urandom_range(99);
			if (r < 60)
				gen_time += $urandom_range(2);
			else if (r < 85)
				gen_time += gen_settle + $urandom_range(2);
			else
				gen_time += $urandom_range(2 * gen_settle + 3);
			t = gen_time;
			if (burst_left > 0) begin
				chg = 1'b1;
				burst_left--;
			end else if ($urandom_range(99) < 4) begin
				chg = 1'b1;
				burst_left = gen_limit + 1;
			end else begin
				chg = ($urandom_range(99) < 20);
			end
			case ($urandom_range(5))
			0: s = 12'(gen_level - gen_margin + $urandom_range(2) - 1);
			1: s = 12'(gen_level + gen_margin + $urandom_range(2) - 1);
			2: s = 12'(gen_level + $urandom_range(2 * gen_margin) - gen_margin);
			3: s = $urandom_range(1) ? 12'd4095 : 12'd0;
			default: s = 12'($urandom_range(4095));
			endcase
			ok = ($urandom_range(99) < 90);
		end
		send(op, chg, t, s, ok);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_POLL;
		change_seen = 1'b0;
		now_seconds = '0;
		proximity_sample = '0;
		read_ok = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		gen_level = 12'd208;
		gen_margin = 8'd48;
		gen_settle = 8'd5;
		gen_limit = 4'd3;
		gen_time = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed checks at the reset configuration.
		send(OP_POLL, 1'b1, 32'd100, 12'd200, 1'b1);
		send(OP_ARM, 1'b1, 32'd100, 12'd4095, 1'b0);
		send(OP_POLL, 1'b0, 32'd105, 12'd200, 1'b1);
		send(OP_POLL, 1'b0, 32'd106, 12'd160, 1'b1);
		send(OP_ARM, 1'b0, 32'd200, 12'd0, 1'b1);
		send(OP_POLL, 1'b0, 32'd206, 12'd161, 1'b1);
		send(OP_POLL, 1'b0, 32'd300, 12'd100, 1'b1);
		send(OP_ARM, 1'b0, 32'd300, 12'd0, 1'b1);
		send(OP_POLL, 1'b0, 32'd306, 12'd255, 1'b1);
		send(OP_ARM, 1'b0, 32'd400, 12'd0, 1'b1);
		send(OP_POLL, 1'b0, 32'd406, 12'd256, 1'b1);
		send(OP_ARM, 1'b0, 32'd500, 12'd0, 1'b1);
		send(OP_POLL, 1'b0, 32'd506, 12'd200, 1'b0);
		for (int i = 0; i < 4; i++)
			send(OP_POLL, 1'b1, 32'd510 + i, 12'd200, 1'b1);
		send(OP_POLL, 1'b0, 32'd519, 12'd200, 1'b1);
		// The deadline sum wraps, so the next poll is judged at once.
		send(OP_ARM, 1'b0, 32'hFFFF_FFFE, 12'd0, 1'b1);
		send(OP_POLL, 1'b0, 32'hFFFF_FFFF, 12'd4095, 1'b1);

		// A limit of zero, and a window whose lower bound lies below zero.
		drain();
		apply_config(12'd48, 8'd100, 8'd5, 4'd0);
		send(OP_ARM, 1'b0, 32'd1000, 12'd0, 1'b1);
		send(OP_POLL, 1'b1, 32'd1001, 12'd0, 1'b1);
		send(OP_POLL, 1'b0, 32'd1007, 12'd0, 1'b1);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
			0: apply_config(12'd48, 8'd1, 8'd1, 4'd1);
			1: apply_config(12'd4047, 8'd255, 8'd255, 4'd15);
			2: apply_config(12'd48, 8'd255, 8'd3, 4'd0);
			3: apply_config(12'd208, 8'd48, 8'd5, 4'd3);
			default: apply_config(12'($urandom_range(4047, 48)),
				8'($urandom_range(255, 1)), 8'($urandom_range(12, 1)),
				4'($urandom_range(15, 1)));
			endcase
			case (phase % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 55;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 55;
			end
			default: begin
				send_idle_pct = 38;
				stall_pct = 38;
			end
			endcase
			gen_time = (phase == 1) ? 32'hFFFF_FF00 : $urandom;
			burst_left = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 4 && n == 40)
					hold_left = 300;
				if (phase == 5 && n == 60)
					drain();
				send_random(n == 0);
			end
		end

		drain();
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
